// ===== hw/rtl/dfw_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal field writer package
// Shared types, constants and the digit split helper for the LCD field writer.
// ----------------------------------------------------------------------------
package dfw_pkg;

	localparam int unsigned VALUE_W   = 14;
	localparam int unsigned ADDR_W    = 8;
	localparam int unsigned FRAME_W   = 24;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned NUM_DIGITS = 4;
	localparam int unsigned IDX_W     = 3;

	localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;
	localparam logic [VALUE_W-1:0] WEIGHT_THO = 14'd1000;
	localparam logic [VALUE_W-1:0] WEIGHT_HUN = 14'd100;
	localparam logic [VALUE_W-1:0] WEIGHT_TEN = 14'd10;

	localparam logic [7:0] SYNC_CMD   = 8'hF8;
	localparam logic [7:0] SYNC_DATA  = 8'hFA;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

	// Digits of one item, thousands in entry 0, with the base address.
	typedef struct packed {
		logic [ADDR_W-1:0]                   base;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  dig;
	} dfw_digits_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [VALUE_W-1:0] rem;
	} dfw_split_t;

	// Extracts one decimal digit by comparing against the nine multiples of
	// a constant weight. The input must stay below ten times the weight.
	function automatic dfw_split_t split_digit(input logic [VALUE_W-1:0] v,
			input logic [VALUE_W-1:0] weight);
		dfw_split_t         res;
		logic [VALUE_W-1:0] mult;
		res.digit = '0;
		res.rem   = v;
		mult      = '0;
		for (int k = 1; k <= 9; k++) begin
			mult = mult + weight;
			if (v >= mult) begin
				res.digit = DIGIT_W'(k);
				res.rem   = v - mult;
			end
		end
		return res;
	endfunction

	// Builds a serial frame: sync byte, high nibble then four zeros, low
	// nibble then four zeros.
	function automatic logic [FRAME_W-1:0] build_frame(input logic [7:0] sync,
			input logic [7:0] payload);
		return {sync, payload[7:4], 4'b0000, payload[3:0], 4'b0000};
	endfunction

endpackage

// ===== hw/rtl/dfw_in_if.sv =====
// ----------------------------------------------------------------------------
// Decimal field writer request channel
// Valid/ready channel carrying a value and the start address.
// ----------------------------------------------------------------------------
interface dfw_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] value;
	logic [7:0]  start_address;

	modport source (output valid, output value, output start_address, input ready);
	modport sink   (input valid, input value, input start_address, output ready);
endinterface

// ===== hw/rtl/dfw_out_if.sv =====
// ----------------------------------------------------------------------------
// Decimal field writer frame channel
// Valid/ready channel carrying one serial LCD frame per transfer.
// ----------------------------------------------------------------------------
interface dfw_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] frame;
	logic        is_data;
	logic        last_frame;

	modport source (output valid, output frame, output is_data, output last_frame,
		input ready);
	modport sink   (input valid, input frame, input is_data, input last_frame,
		output ready);
endinterface

// ===== hw/rtl/dfw_digits.sv =====
// ----------------------------------------------------------------------------
// Decimal field writer digit pipeline
// Three register stages that saturate the value and peel off its digits.
// ----------------------------------------------------------------------------
module dfw_digits (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [13:0]           value,
	input  logic [7:0]            start_address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dfw_pkg::dfw_digits_t  out_data
);
	import dfw_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic               adv1, adv2, adv3;
	logic [VALUE_W-1:0] sat_v;
	dfw_split_t         split1, split2, split3;
	dfw_digits_t        dig_nxt1, dig_nxt2, dig_nxt3;

	logic [VALUE_W-1:0] rem_s1, rem_s2;
	dfw_digits_t        dig_s1, dig_s2, dig_s3;

	// A stage moves forward when the one after it is empty or moving.
	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		sat_v  = (value > VALUE_MAX) ? VALUE_MAX : value;
		split1 = split_digit(sat_v, WEIGHT_THO);
		split2 = split_digit(rem_s1, WEIGHT_HUN);
		split3 = split_digit(rem_s2, WEIGHT_TEN);

		// Each stage adds its digits to the record handed on by the stage
		// before it.
		dig_nxt1        = '0;
		dig_nxt1.base   = start_address;
		dig_nxt1.dig[0] = split1.digit;
		dig_nxt2        = dig_s1;
		dig_nxt2.dig[1] = split2.digit;
		dig_nxt3        = dig_s2;
		dig_nxt3.dig[2] = split3.digit;
		dig_nxt3.dig[3] = split3.rem[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			rem_s1 <= split1.rem;
			dig_s1 <= dig_nxt1;
		end
		if (adv2) begin
			rem_s2 <= split2.rem;
			dig_s2 <= dig_nxt2;
		end
		if (adv3) begin
			dig_s3 <= dig_nxt3;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = dig_s3;

	// The remainder after the thousands digit must be below one thousand.
	a_rem1_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (rem_s1 < WEIGHT_THO))
		else $error("thousands remainder out of range");

	// The last stage holds its item while the receiver stalls.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_ready) |=> (valid_s3 && $stable(dig_s3)))
		else $error("stage three lost an item under stall");

	// Every digit leaving the pipeline is a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (dig_s3.dig[0] <= 4'd9 && dig_s3.dig[1] <= 4'd9 &&
			dig_s3.dig[2] <= 4'd9 && dig_s3.dig[3] <= 4'd9))
		else $error("digit above nine");

endmodule

// ===== hw/rtl/dfw_framer.sv =====
// ----------------------------------------------------------------------------
// Decimal field writer framer
// Holds one item of digits and sends its eight frames through an output
// register, one frame per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module dfw_framer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dfw_pkg::dfw_digits_t  in_data,
	dfw_out_if.source             result
);
	import dfw_pkg::*;

	logic               busy_q;
	logic [IDX_W-1:0]   idx_q;
	dfw_digits_t        item_q;
	logic               out_valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic               is_data_q;
	logic               last_q;

	logic               out_load;
	logic               emit;
	logic               take;
	logic [1:0]         pos;
	logic [7:0]         addr;
	logic [7:0]         ch;
	logic [7:0]         payload;
	logic [7:0]         sync;

	assign out_load = !out_valid_q || result.ready;
	assign emit     = busy_q && out_load;
	assign in_ready = !busy_q || (emit && idx_q == LAST_IDX);
	assign take     = in_valid && in_ready;

	// Odd frame numbers are data frames; the digit position is the pair index.
	always_comb begin
		pos     = idx_q[IDX_W-1:1];
		addr    = item_q.base + {6'b000000, pos};
		ch      = ASCII_ZERO + {4'b0000, item_q.dig[pos]};
		payload = idx_q[0] ? ch : addr;
		sync    = idx_q[0] ? SYNC_DATA : SYNC_CMD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= busy_q;
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST_IDX) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_q <= in_data;
		if (emit) begin
			frame_q   <= build_frame(sync, payload);
			is_data_q <= idx_q[0];
			last_q    <= (idx_q == LAST_IDX);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.frame      = frame_q;
	assign result.is_data    = is_data_q;
	assign result.last_frame = last_q;

	// The final frame of an item is always a data frame.
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> is_data_q)
		else $error("last frame is not a data frame");

	// Within an item the frame counter steps by one per emitted frame.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !take && idx_q != LAST_IDX) |=>
			(busy_q && idx_q == $past(idx_q) + 3'd1))
		else $error("frame counter skipped");

	// A new item is only taken when the current one is done or finishing.
	a_take_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && busy_q) |-> (emit && idx_q == LAST_IDX))
		else $error("item overwritten before all frames left");

endmodule

// ===== hw/rtl/decimal_field_lcd_serial_writer.sv =====
// ----------------------------------------------------------------------------
// Decimal field LCD serial writer
// Turns a value of up to four decimal digits into eight serial LCD frames.
// ----------------------------------------------------------------------------
// Usage:
// A request on the item channel carries a value and a start address. The
// value is saturated to 9999 and split into four digits, thousands first.
// For each digit the result channel carries an address command frame (sync
// 0xF8, address start_address plus the digit position, wrapping at 256) and
// then a data frame (sync 0xFA, the ASCII digit). last_frame marks the
// eighth frame of the request.
// The request passes the three digit stages, the framer's item register and
// its output register before the first frame shows; the other seven follow
// one per cycle unless the receiver stalls. The framer takes a new request
// as the last frame of the current one enters its single output register.
// The digit pipeline in front of it keeps up to three further requests, so
// the item channel stays ready while frames drain.
// Reset clears all valid bits and the frame counter; no request is held.
// When the receiver stalls, the output frame holds, the framer pauses and
// the digit pipeline fills and then drops ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module decimal_field_lcd_serial_writer (
	input  logic       clk,
	input  logic       arst_n,
	dfw_in_if.sink     item,
	dfw_out_if.source  result
);
	import dfw_pkg::*;

	// Handshake between the digit pipeline and the framer.
	logic        dig_valid;
	logic        dig_ready;
	dfw_digits_t dig_data;

	// Three stages: saturate and thousands digit, hundreds digit, tens and
	// units digits.
	dfw_digits u_digits (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (item.valid),
		.in_ready      (item.ready),
		.value         (item.value),
		.start_address (item.start_address),
		.out_valid     (dig_valid),
		.out_ready     (dig_ready),
		.out_data      (dig_data)
	);

	// The framer takes the next item in the same cycle as the last frame of
	// the current one is loaded into its output register, so frames run back to back.
	dfw_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dig_valid),
		.in_ready (dig_ready),
		.in_data  (dig_data),
		.result   (result)
	);

endmodule
